/* hdl/mlmf_pkg.sv */
package mlmf_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_HOLD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAN_SHORT_TO = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAN_LONG_TO  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_STEP    = 3'd4;

   // register reset values
   localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
   localparam logic [31:0] MOTION_HOLD_RST  = 32'd120000;
   localparam logic [31:0] MAN_SHORT_TO_RST = 32'd3600000;
   localparam logic [31:0] MAN_LONG_TO_RST  = 32'd14400000;
   localparam logic [7:0]  FADE_STEP_RST    = 8'd10;

   // brightness constants
   localparam logic [7:0] LEVEL_MAX  = 8'd255;
   localparam logic [7:0] LEVEL_GATE = 8'd100;
   localparam logic [7:0] LEVEL_KICK = 8'd5;

   typedef struct packed {
      logic        motion;
      logic        button_down;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] level_a;
      logic [7:0] level_b;
      logic [7:0] level_c;
      logic       light_wanted;
      logic       in_manual;
   } rsp_type;

   // classified pass handed from front to back
   typedef struct packed {
      logic        motion;
      logic [31:0] now_ms;
      logic        short_press;
      logic        long_press;
      logic        force_c;
   } cmd_type;

   // settings used by the back end
   typedef struct packed {
      logic [31:0] motion_hold_ms;
      logic [31:0] manual_short_timeout_ms;
      logic [31:0] manual_long_timeout_ms;
      logic [7:0]  fade_step_ms;
   } cfg_type;

endpackage

/* hdl/motion_light_mode_fader_top.sv */
// Motion light controller with auto/manual modes and a three-channel fader.
// Input queue: drive req_data and raise req_push; a transaction is taken on
// a rising edge with req_push high and req_full low. Each transaction is one
// control pass (motion level, button level, millisecond timestamp).
// Result queue: while rsp_empty is low the oldest result sits on rsp_data;
// raise rsp_pop to take it. Exactly one result per accepted pass, in order.
// Settings port: csr_valid/csr_ready with csr_index and csr_wdata; csr_ready
// is always high. Write settings only while no pass is in flight.
// Throughput is one pass per cycle unless the result queue is full: the front
// end (button classifier) and back end (mode logic plus fader) each handle a
// pass combinationally, with two-entry queues between them and at the output.
// An accepted pass is stored in the middle queue; the back end handles it as
// it leaves, and its result is held in the result queue until it is popped.
// When the receiver stops popping, the result queue fills, the back end
// holds, the middle queue fills, and req_full rises; nothing is dropped.
// Synchronous reset clears all mode and fader state, empties both queues
// and restores the settings to their default values.
module motion_light_mode_fader_top #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  mlmf_pkg::req_type                    req_data,
   output logic                                 req_full,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output mlmf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mlmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata
);
   import mlmf_pkg::*;

   logic [15:0] long_press_ff;
   cfg_type     cfg_ff;
   logic        req_accept;
   cmd_type     front_cmd;
   cmd_type     back_cmd;
   logic        cmd_full;
   logic        cmd_empty;
   logic        rsp_full;
   logic        back_fire;
   rsp_type     back_rsp;

   assign csr_ready  = 1'b1;
   assign req_full   = cmd_full;
   assign req_accept = req_push && !cmd_full;
   assign back_fire  = !cmd_empty && !rsp_full;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff                  <= LONG_PRESS_RST;
         cfg_ff.motion_hold_ms          <= MOTION_HOLD_RST;
         cfg_ff.manual_short_timeout_ms <= MAN_SHORT_TO_RST;
         cfg_ff.manual_long_timeout_ms  <= MAN_LONG_TO_RST;
         cfg_ff.fade_step_ms            <= FADE_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LONG_PRESS: begin
               long_press_ff <= csr_wdata[15:0];
            end
            CSR_MOTION_HOLD: begin
               cfg_ff.motion_hold_ms <= csr_wdata;
            end
            CSR_MAN_SHORT_TO: begin
               cfg_ff.manual_short_timeout_ms <= csr_wdata;
            end
            CSR_MAN_LONG_TO: begin
               cfg_ff.manual_long_timeout_ms <= csr_wdata;
            end
            CSR_FADE_STEP: begin
               cfg_ff.fade_step_ms <= csr_wdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   mlmf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .req           (req_data),
      .long_press_ms (long_press_ff),
      .cmd           (front_cmd)
   );

   mlmf_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_accept),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (back_fire),
      .rd_data (back_cmd),
      .empty   (cmd_empty)
   );

   mlmf_back u_back (
      .clock (clock),
      .reset (reset),
      .fire  (back_fire),
      .cmd   (back_cmd),
      .cfg   (cfg_ff),
      .rsp   (back_rsp)
   );

   mlmf_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (back_fire),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

/* hdl/mlmf_fifo.sv */
module mlmf_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed transaction
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fifo occupancy above depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fifo count did not grow on push");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("fifo pointers disagree with occupancy");

endmodule

/* hdl/mlmf_front.sv */
module mlmf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  mlmf_pkg::req_type req,
   input  logic [15:0]       long_press_ms,
   output mlmf_pkg::cmd_type cmd
);
   import mlmf_pkg::*;

   logic        held_ff, held_in;
   logic [31:0] press_mark_ff, press_mark_in;
   logic [31:0] held_time;
   logic [31:0] long_limit;

   assign held_time  = req.now_ms - press_mark_ff;
   assign long_limit = {16'd0, long_press_ms};

   // classify press and release edges of the button, and flag a press held past the limit
   always_comb begin
      held_in         = held_ff;
      press_mark_in   = press_mark_ff;
      cmd.motion      = req.motion;
      cmd.now_ms      = req.now_ms;
      cmd.short_press = 1'b0;
      cmd.long_press  = 1'b0;
      cmd.force_c     = req.button_down && held_ff && (held_time > long_limit);
      if (req.button_down && !held_ff) begin
         held_in       = 1'b1;
         press_mark_in = req.now_ms;
      end else if (!req.button_down && held_ff) begin
         held_in       = 1'b0;
         press_mark_in = '0;
         if (held_time < long_limit) begin
            cmd.short_press = 1'b1;
         end else begin
            cmd.long_press = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 1'b0;
         press_mark_ff <= '0;
      end else if (accept) begin
         held_ff       <= held_in;
         press_mark_ff <= press_mark_in;
      end
   end

endmodule

/* hdl/mlmf_back.sv */
module mlmf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  mlmf_pkg::cmd_type cmd,
   input  mlmf_pkg::cfg_type cfg,
   output mlmf_pkg::rsp_type rsp
);
   import mlmf_pkg::*;

   logic        light_ff, light_in;
   logic        manual_ff, manual_in;
   logic        use_long_ff, use_long_in;
   logic        quiet_flag_ff, quiet_flag_in;
   logic        entered_ff, entered_in;
   logic        motion_flag_ff, motion_flag_in;
   logic [31:0] quiet_mark_ff, quiet_mark_in;
   logic [31:0] motion_mark_ff, motion_mark_in;
   logic [31:0] fade_mark_ff, fade_mark_in;
   logic [7:0]  bright_a_ff, bright_a_in;
   logic [7:0]  bright_b_ff, bright_b_in;
   logic [7:0]  bright_c_ff, bright_c_in;
   logic [31:0] limit;
   logic [31:0] quiet_time;
   logic [31:0] motion_time;
   logic [31:0] fade_time;

   assign motion_time = cmd.now_ms - motion_mark_ff;
   assign fade_time   = cmd.now_ms - fade_mark_ff;

   // mode logic then at most one fader step
   always_comb begin
      light_in       = light_ff;
      manual_in      = manual_ff;
      use_long_in    = use_long_ff;
      quiet_flag_in  = quiet_flag_ff;
      entered_in     = entered_ff;
      motion_flag_in = motion_flag_ff;
      quiet_mark_in  = quiet_mark_ff;
      motion_mark_in = motion_mark_ff;
      fade_mark_in   = fade_mark_ff;
      bright_a_in    = bright_a_ff;
      bright_b_in    = bright_b_ff;
      bright_c_in    = cmd.force_c ? LEVEL_KICK : bright_c_ff;
      limit          = '0;
      quiet_time     = '0;

      if (manual_ff) begin
         if (!entered_ff) begin
            quiet_mark_in = cmd.now_ms;
            entered_in    = 1'b1;
         end
         if (cmd.short_press) begin
            light_in = !light_ff;
         end
         if (cmd.long_press) begin
            use_long_in   = 1'b0;
            manual_in     = 1'b0;
            bright_c_in   = LEVEL_KICK;
            quiet_flag_in = 1'b0;
         end
         if (!cmd.motion && !quiet_flag_in) begin
            quiet_flag_in = 1'b1;
            quiet_mark_in = cmd.now_ms;
         end else if (cmd.motion && quiet_flag_in) begin
            quiet_flag_in = 1'b0;
            quiet_mark_in = cmd.now_ms;
         end
         limit      = use_long_in ? cfg.manual_long_timeout_ms
                                  : cfg.manual_short_timeout_ms;
         quiet_time = cmd.now_ms - quiet_mark_in;
         if (quiet_time > limit) begin
            manual_in     = 1'b0;
            quiet_flag_in = 1'b0;
            use_long_in   = 1'b0;
            quiet_mark_in = cmd.now_ms;
         end
      end else begin
         entered_in = 1'b0;
         if (cmd.motion && !motion_flag_ff) begin
            motion_flag_in = 1'b1;
            light_in       = 1'b1;
            motion_mark_in = cmd.now_ms;
         end
         if (!cmd.motion && motion_flag_ff) begin
            motion_flag_in = 1'b0;
            motion_mark_in = cmd.now_ms;
         end else if (light_ff && !cmd.motion && (motion_time > cfg.motion_hold_ms)) begin
            light_in = 1'b0;
         end
         if (cmd.short_press) begin
            use_long_in = 1'b0;
            manual_in   = 1'b1;
            bright_b_in = LEVEL_KICK;
         end
         if (cmd.long_press) begin
            use_long_in = 1'b1;
            manual_in   = 1'b1;
            bright_a_in = LEVEL_KICK;
         end
      end

      // step channels in order a, b, c with cross gating
      if (fade_time > {24'd0, cfg.fade_step_ms}) begin
         fade_mark_in = cmd.now_ms;
         if (light_in) begin
            if (bright_a_in != LEVEL_MAX) begin
               bright_a_in = bright_a_in + 1'b1;
            end
            if (bright_b_in != LEVEL_MAX && bright_c_in > LEVEL_GATE) begin
               bright_b_in = bright_b_in + 1'b1;
            end
            if (bright_c_in != LEVEL_MAX && bright_a_in > LEVEL_GATE) begin
               bright_c_in = bright_c_in + 1'b1;
            end
         end else begin
            if (bright_a_in != '0 && bright_b_in < LEVEL_GATE) begin
               bright_a_in = bright_a_in - 1'b1;
            end
            if (bright_b_in != '0) begin
               bright_b_in = bright_b_in - 1'b1;
            end
            if (bright_c_in != '0 && bright_a_in < LEVEL_GATE) begin
               bright_c_in = bright_c_in - 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp.level_a      = bright_a_in;
      rsp.level_b      = bright_b_in;
      rsp.level_c      = bright_c_in;
      rsp.light_wanted = light_in;
      rsp.in_manual    = manual_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff       <= 1'b0;
         manual_ff      <= 1'b0;
         use_long_ff    <= 1'b0;
         quiet_flag_ff  <= 1'b0;
         entered_ff     <= 1'b0;
         motion_flag_ff <= 1'b0;
         quiet_mark_ff  <= '0;
         motion_mark_ff <= '0;
         fade_mark_ff   <= '0;
         bright_a_ff    <= '0;
         bright_b_ff    <= '0;
         bright_c_ff    <= '0;
      end else if (fire) begin
         light_ff       <= light_in;
         manual_ff      <= manual_in;
         use_long_ff    <= use_long_in;
         quiet_flag_ff  <= quiet_flag_in;
         entered_ff     <= entered_in;
         motion_flag_ff <= motion_flag_in;
         quiet_mark_ff  <= quiet_mark_in;
         motion_mark_ff <= motion_mark_in;
         fade_mark_ff   <= fade_mark_in;
         bright_a_ff    <= bright_a_in;
         bright_b_ff    <= bright_b_in;
         bright_c_ff    <= bright_c_in;
      end
   end

endmodule

/* sim/light_pass_compare.sv */
`timescale 1ns / 1ps

module light_pass_compare (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_full,
   input  mlmf_pkg::req_type                req_data,
   input  logic                             rsp_empty,
   input  logic                             rsp_pop,
   input  mlmf_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [mlmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata,
   input  logic                             end_of_test,
   output int                               mismatches,
   output int                               outstanding
);
   import mlmf_pkg::*;

   // settings as the block should hold them
   logic [15:0] cfg_long_press;
   logic [31:0] cfg_hold;
   logic [31:0] cfg_short_to;
   logic [31:0] cfg_long_to;
   logic [7:0]  cfg_fade;

   // mode and fader state mirrored from the block
   logic        light_on, held, short_req, long_req, manual, long_to_sel;
   logic        quiet, entered, moving;
   logic [31:0] fade_t, press_t, quiet_t, motion_t;
   logic [7:0]  lvl_a, lvl_b, lvl_c;

   // levels owed to the receiver, oldest first
   rsp_type     owed_levels[$];
   logic        leftover_done;

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      leftover_done = 1'b0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      $display("MISMATCH at %0t: %s: expected %0h, got %0h", $realtime, what, want, got);
      mismatches++;
   endtask

   // one control pass: button, mode logic, then fader
   task automatic run_control_pass(input req_type pass, output rsp_type res);
      logic [31:0] now;
      logic [31:0] limit;
      now = pass.now_ms;

      // classify button edges
      if (pass.button_down && !held) begin
         held    = 1'b1;
         press_t = now;
      end else if (!pass.button_down && held) begin
         held = 1'b0;
         if (now - press_t < {16'd0, cfg_long_press}) short_req = 1'b1;
         else long_req = 1'b1;
         press_t = '0;
      end
      if (pass.button_down && now - press_t > {16'd0, cfg_long_press}) lvl_c = LEVEL_KICK;

      if (manual) begin
         if (!entered) begin
            quiet_t = now;
            entered = 1'b1;
         end
         if (short_req) begin
            short_req = 1'b0;
            light_on  = !light_on;
         end
         // long press drops manual but the quiet tracking still runs below
         if (long_req) begin
            long_req    = 1'b0;
            long_to_sel = 1'b0;
            manual      = 1'b0;
            lvl_c       = LEVEL_KICK;
            quiet       = 1'b0;
         end
         if (!pass.motion && !quiet) begin
            quiet   = 1'b1;
            quiet_t = now;
         end else if (pass.motion && quiet) begin
            quiet   = 1'b0;
            quiet_t = now;
         end
         limit = long_to_sel ? cfg_long_to : cfg_short_to;
         if (now - quiet_t > limit) begin
            manual      = 1'b0;
            quiet       = 1'b0;
            long_to_sel = 1'b0;
            quiet_t     = now;
         end
      end else begin
         entered = 1'b0;
         if (pass.motion && !moving) begin
            moving   = 1'b1;
            light_on = 1'b1;
            motion_t = now;
         end
         if (!pass.motion && moving) begin
            moving   = 1'b0;
            motion_t = now;
         end else if (light_on && !pass.motion && now - motion_t > cfg_hold) begin
            light_on = 1'b0;
         end
         if (short_req) begin
            short_req   = 1'b0;
            long_to_sel = 1'b0;
            manual      = 1'b1;
            lvl_b       = LEVEL_KICK;
         end
         if (long_req) begin
            long_req    = 1'b0;
            long_to_sel = 1'b1;
            manual      = 1'b1;
            lvl_a       = LEVEL_KICK;
         end
      end

      // fade one step, channels in order, each seeing the updated ones
      if (now - fade_t > {24'd0, cfg_fade}) begin
         fade_t = now;
         if (light_on) begin
            if (lvl_a != LEVEL_MAX) lvl_a = lvl_a + 8'd1;
            if (lvl_b != LEVEL_MAX && lvl_c > LEVEL_GATE) lvl_b = lvl_b + 8'd1;
            if (lvl_c != LEVEL_MAX && lvl_a > LEVEL_GATE) lvl_c = lvl_c + 8'd1;
         end else begin
            if (lvl_a != 8'd0 && lvl_b < LEVEL_GATE) lvl_a = lvl_a - 8'd1;
            if (lvl_b != 8'd0) lvl_b = lvl_b - 8'd1;
            if (lvl_c != 8'd0 && lvl_a < LEVEL_GATE) lvl_c = lvl_c - 8'd1;
         end
      end

      res.level_a      = lvl_a;
      res.level_b      = lvl_b;
      res.level_c      = lvl_c;
      res.light_wanted = light_on;
      res.in_manual    = manual;
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      rsp_type pred;
      if (reset) begin
         // restore defaults and clear everything
         cfg_long_press = LONG_PRESS_RST;
         cfg_hold       = MOTION_HOLD_RST;
         cfg_short_to   = MAN_SHORT_TO_RST;
         cfg_long_to    = MAN_LONG_TO_RST;
         cfg_fade       = FADE_STEP_RST;
         {light_on, held, short_req, long_req, manual, long_to_sel} = '0;
         {quiet, entered, moving} = '0;
         {fade_t, press_t, quiet_t, motion_t} = '0;
         {lvl_a, lvl_b, lvl_c} = '0;
         owed_levels.delete();
      end else begin
         // track settings writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LONG_PRESS:   cfg_long_press = csr_wdata[15:0];
               CSR_MOTION_HOLD:  cfg_hold       = csr_wdata;
               CSR_MAN_SHORT_TO: cfg_short_to   = csr_wdata;
               CSR_MAN_LONG_TO:  cfg_long_to    = csr_wdata;
               CSR_FADE_STEP:    cfg_fade       = csr_wdata[7:0];
               default: ;
            endcase
         end

         // compare each delivered result with the oldest owed one
         if (rsp_pop && !rsp_empty) begin
            if (owed_levels.size() == 0) begin
               flag_mismatch("result with nothing owed", '0, 32'(rsp_data));
            end else begin
               want = owed_levels.pop_front();
               if (rsp_data.level_a != want.level_a)
                  flag_mismatch("level_a", 32'(want.level_a), 32'(rsp_data.level_a));
               if (rsp_data.level_b != want.level_b)
                  flag_mismatch("level_b", 32'(want.level_b), 32'(rsp_data.level_b));
               if (rsp_data.level_c != want.level_c)
                  flag_mismatch("level_c", 32'(want.level_c), 32'(rsp_data.level_c));
               if (rsp_data.light_wanted != want.light_wanted)
                  flag_mismatch("light_wanted", 32'(want.light_wanted),
                                32'(rsp_data.light_wanted));
               if (rsp_data.in_manual != want.in_manual)
                  flag_mismatch("in_manual", 32'(want.in_manual),
                                32'(rsp_data.in_manual));
            end
         end

         // predict each accepted pass
         if (req_push && !req_full) begin
            run_control_pass(req_data, pred);
            owed_levels.push_back(pred);
         end

         if (end_of_test && !leftover_done) begin
            leftover_done = 1'b1;
            if (owed_levels.size() != 0)
               flag_mismatch("results never delivered", '0, 32'(owed_levels.size()));
         end
      end
      outstanding = owed_levels.size();
   end

endmodule

/* sim/motion_light_mode_fader_top_tb.sv */
`timescale 1ns / 1ps

module motion_light_mode_fader_top_tb;
   import mlmf_pkg::*;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   req_type                req_data  = '0;
   logic                   req_full;
   logic                   rsp_empty;
   logic                   rsp_pop   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_wdata = '0;
   logic                   end_of_test = 1'b0;
   int                     mismatches;
   int                     outstanding;

   // traffic shaping knobs, set per phase
   int                     send_idle_pct = 0;
   int                     pop_stall_pct = 0;
   int                     hold_req      = 0;

   // timeline of the random passes
   logic [31:0]            stamp;
   logic                   btn_level;
   logic                   mot_level;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   motion_light_mode_fader_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   light_pass_compare pass_compare (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .end_of_test (end_of_test),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // receiver: random stalls, plus a long hold-off on request
   initial begin : pop_driver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   // offer one pass and hold it until the block takes it
   task automatic send_pass(input logic mot, input logic btn, input logic [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_data <= '{motion: mot, button_down: btn, now_ms: now};
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic write_setting(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drain all owed results, then let the pipeline go quiet
   task automatic settle();
      int waited;
      waited = 0;
      req_push <= 1'b0;
      while (outstanding != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (6) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_setting(input logic [31:0] top_val,
                                                input int unsigned small_max);
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return top_val;
      return $urandom_range(small_max, 1);
   endfunction

   // random settings, then a stream of mostly well-formed passes
   task automatic run_phase(input int n_items);
      int unsigned roll;
      int unsigned span;
      logic [31:0] delta;
      write_setting(CSR_LONG_PRESS, pick_setting(32'h0000_FFFF, 300));
      write_setting(CSR_MOTION_HOLD, pick_setting(32'hFFFF_FFFF, 500));
      write_setting(CSR_MAN_SHORT_TO, pick_setting(32'hFFFF_FFFF, 2000));
      write_setting(CSR_MAN_LONG_TO, pick_setting(32'hFFFF_FFFF, 2000));
      write_setting(CSR_FADE_STEP, pick_setting(32'h0000_00FF, 20));
      stamp     = $urandom;
      btn_level = 1'($urandom_range(1));
      mot_level = 1'($urandom_range(1));
      span      = $urandom_range(40, 2);
      for (int k = 0; k < n_items; k++) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            // noise: anything at all
            send_pass(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
         end else begin
            if ($urandom_range(7) == 0) btn_level = ~btn_level;
            if ($urandom_range(9) == 0) mot_level = ~mot_level;
            roll = $urandom_range(99);
            if (roll < 10) delta = '0;
            else if (roll < 85) delta = $urandom_range(span, 0);
            else if (roll < 97) delta = $urandom_range(span * 30, 0);
            else delta = $urandom;
            stamp = stamp + delta;
            send_pass(mot_level, btn_level, stamp);
         end
      end
      settle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: presses, mode kicks, held button, wrap
      send_pass(1'b0, 1'b0, 32'd0);
      send_pass(1'b1, 1'b0, 32'd11);
      send_pass(1'b1, 1'b1, 32'd22);
      send_pass(1'b1, 1'b1, 32'd1100);
      send_pass(1'b0, 1'b0, 32'd1200);
      send_pass(1'b0, 1'b1, 32'd1300);
      send_pass(1'b0, 1'b0, 32'd1400);
      send_pass(1'b1, 1'b1, 32'd1500);
      send_pass(1'b1, 1'b0, 32'd3000);
      send_pass(1'b0, 1'b0, 32'hFFFF_FFF0);
      send_pass(1'b0, 1'b0, 32'h0000_0010);
      send_pass(1'b1, 1'b1, 32'hFFFF_FFFF);
      send_pass(1'b0, 1'b0, 32'h0000_0000);
      settle();

      // all settings at zero; unknown indexes must change nothing
      write_setting(CSR_LONG_PRESS, '0);
      write_setting(CSR_MOTION_HOLD, '0);
      write_setting(CSR_MAN_SHORT_TO, '0);
      write_setting(CSR_MAN_LONG_TO, '0);
      write_setting(CSR_FADE_STEP, '0);
      for (int i = CSR_FADE_STEP + 1; i < 2 ** CSR_INDEX_W; i++)
         write_setting(i[CSR_INDEX_W-1:0], $urandom);
      send_pass(1'b0, 1'b1, 32'd100);
      send_pass(1'b1, 1'b1, 32'd101);
      send_pass(1'b0, 1'b0, 32'd102);
      send_pass(1'b0, 1'b0, 32'd102);
      send_pass(1'b0, 1'b0, 32'd103);
      send_pass(1'b0, 1'b1, 32'd104);
      send_pass(1'b0, 1'b0, 32'd104);
      settle();

      // all settings at their maximum
      write_setting(CSR_LONG_PRESS, 32'h0000_FFFF);
      write_setting(CSR_MOTION_HOLD, 32'hFFFF_FFFF);
      write_setting(CSR_MAN_SHORT_TO, 32'hFFFF_FFFF);
      write_setting(CSR_MAN_LONG_TO, 32'hFFFF_FFFF);
      write_setting(CSR_FADE_STEP, 32'h0000_00FF);
      send_pass(1'b1, 1'b1, 32'd0);
      send_pass(1'b1, 1'b0, 32'd65534);
      send_pass(1'b0, 1'b1, 32'd70000);
      send_pass(1'b0, 1'b1, 32'd140000);
      send_pass(1'b0, 1'b0, 32'd140000);
      send_pass(1'b0, 1'b0, 32'hFFFF_FFFF);
      settle();

      // random phases, cycling through the traffic patterns
      for (int p = 0; p < 6; p++) begin
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               pop_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 77;
               pop_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               pop_stall_pct = 77;
            end
            default: begin
               send_idle_pct = 16;
               pop_stall_pct = 16;
            end
         endcase
         // block the receiver long enough to back the input up
         if (p % 4 == 0) hold_req = 80;
         run_phase(160);
      end

      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
